[rtl/two_pool_block_free_list_assert.svh]
// Assertion macros used by the checker file of this block.
// Each macro takes a label, an antecedent and a consequent, and samples
// on the rising edge of clk with the check switched off while rst_n is low.
`ifndef TWO_POOL_BLOCK_FREE_LIST_ASSERT_SVH
`define TWO_POOL_BLOCK_FREE_LIST_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TPBFL_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tpbfl assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define TPBFL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tpbfl assertion failed");

`endif

[rtl/tpbfl_pkg.sv]
`default_nettype none

package tpbfl_pkg;

  localparam int MAX_BLOCKS_DEF  = 1024;
  localparam int POOL_RESET_SIZE = 1024;
  localparam int CNT_W           = 11;
  localparam int ID_W            = 10;
  localparam int APB_DATA_W      = 32;
  localparam int APB_ADDR_W      = 3;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic REG_CPU_POOL_BLOCKS = 1'b0;
  localparam logic REG_GPU_POOL_BLOCKS = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_size;
    logic             op_valid;
    logic             func;
    logic [ID_W-1:0]  freed_id;
  } pool_req_t;

  typedef struct packed {
    status_t          status;
    logic [CNT_W-1:0] free_left;
    logic [CNT_W-1:0] size;
  } pool_rsp_t;

endpackage

`default_nettype wire

[rtl/two_pool_block_free_list.sv]
`default_nettype none

// Block-id allocator with two independent LIFO pools, cpu (pool 0) and gpu (pool 1).
// A request transaction is taken at each rising edge with start high and busy low;
// busy never rises, so one request may be issued in every cycle.
// Fields: in_func (0 allocate, 1 free), in_pool, in_freed_id (used by free only).
// Each request gives exactly one result in the cycle after it is taken: out_valid is
// high for that single cycle with out_granted_id, out_result_pool, out_status and
// out_free_left. Throughput is one request per cycle, set by the single read port
// of each pool's stack memory, read in the accept cycle. The receiver cannot stall
// the result channel, so results must be taken as shown. The APB port holds the pool
// sizes at byte addresses 0 (cpu) and 4 (gpu); a write refills that pool at once,
// with the smallest ids handed out first. Sizes above MAX_BLOCKS saturate. Writes
// must be made only while no request is in flight; the block does not enforce this.
// Reset is synchronous: both pools are refilled to their reset size and the result
// strobe is cleared. No clearing pass over the memories is needed after reset or a
// refill; a low-water mark per pool tells which entries still hold refill values.

module two_pool_block_free_list #(
  parameter int MAX_BLOCKS = tpbfl_pkg::MAX_BLOCKS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  start,
  output logic                                 busy,
  input  wire                                  in_func,
  input  wire                                  in_pool,
  input  wire  [tpbfl_pkg::ID_W-1:0]           in_freed_id,
  output logic                                 out_valid,
  output logic [tpbfl_pkg::ID_W-1:0]           out_granted_id,
  output logic                                 out_result_pool,
  output logic [1:0]                           out_status,
  output logic [tpbfl_pkg::CNT_W-1:0]          out_free_left,
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire  [tpbfl_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire  [tpbfl_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [tpbfl_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                 pready
);
  import tpbfl_pkg::*;

  pool_req_t       req [2];
  pool_rsp_t       rsp [2];
  logic [ID_W-1:0] pool_gid [2];

  logic accept;
  logic cfg_we;

  logic             out_valid_r;
  logic             out_pool_r;
  status_t          out_status_r;
  logic [CNT_W-1:0] out_free_left_r;
  logic             gnt_ok_r;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start && !busy;
  assign cfg_we = psel && penable && pwrite && pready;

  for (genvar g = 0; g < 2; g++) begin : g_pool
    assign req[g].cfg_we   = cfg_we && (paddr[2] == 1'(g));
    assign req[g].cfg_size = pwdata[CNT_W-1:0];
    assign req[g].op_valid = accept && (in_pool == 1'(g));
    assign req[g].func     = in_func;
    assign req[g].freed_id = in_freed_id;

    tpbfl_pool #(
      .MAX_BLOCKS (MAX_BLOCKS)
    ) u_pool (
      .clk        (clk),
      .rst_n      (rst_n),
      .req        (req[g]),
      .rsp        (rsp[g]),
      .granted_id (pool_gid[g])
    );
  end

  always_comb begin
    unique case (paddr[2])
      REG_CPU_POOL_BLOCKS: prdata = APB_DATA_W'(rsp[0].size);
      REG_GPU_POOL_BLOCKS: prdata = APB_DATA_W'(rsp[1].size);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_pool_r      <= in_pool;
      out_status_r    <= rsp[in_pool].status;
      out_free_left_r <= rsp[in_pool].free_left;
      gnt_ok_r        <= (in_func == FUNC_ALLOC) && (rsp[in_pool].status == ST_OK);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_pool = out_pool_r;
  assign out_status      = out_status_r;
  assign out_free_left   = out_free_left_r;
  assign out_granted_id  = gnt_ok_r ? pool_gid[out_pool_r] : '0;

endmodule

`default_nettype wire

[rtl/tpbfl_pool.sv]
`default_nettype none

module tpbfl_pool #(
  parameter int MAX_BLOCKS = tpbfl_pkg::MAX_BLOCKS_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  tpbfl_pkg::pool_req_t           req,
  output tpbfl_pkg::pool_rsp_t           rsp,
  output logic [tpbfl_pkg::ID_W-1:0]     granted_id
);
  import tpbfl_pkg::*;

  localparam int CW_FULL  = $clog2(MAX_BLOCKS + 1);
  localparam int CW       = (CW_FULL < CNT_W) ? CW_FULL : CNT_W;
  localparam int AW       = $clog2(MAX_BLOCKS);
  localparam int RST_SIZE = (POOL_RESET_SIZE < MAX_BLOCKS) ? POOL_RESET_SIZE : MAX_BLOCKS;

  logic [ID_W-1:0] mem [MAX_BLOCKS];

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] mark_r, mark_nxt;
  logic [CW-1:0] size_r, size_nxt;
  logic [CW-1:0] cap_size;
  logic [CW-1:0] count_dec;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  status_t       status;

  logic [ID_W-1:0] rd_data_r;
  logic [ID_W-1:0] fallback_r;
  logic            use_mem_r;

  always_comb begin
    if (32'(req.cfg_size) > 32'(MAX_BLOCKS)) begin
      cap_size = CW'(MAX_BLOCKS);
    end else begin
      cap_size = CW'(req.cfg_size);
    end
  end

  assign count_dec = count_r - CW'(1);
  assign wr_addr   = AW'(count_r);
  assign rd_addr   = AW'(count_dec);

  always_comb begin
    count_nxt = count_r;
    mark_nxt  = mark_r;
    size_nxt  = size_r;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    status    = ST_OK;
    if (req.cfg_we) begin
      size_nxt  = cap_size;
      count_nxt = cap_size;
      mark_nxt  = cap_size;
    end else if (req.op_valid) begin
      if (req.func == FUNC_ALLOC) begin
        if (count_r == '0) begin
          status = ST_EMPTY;
        end else begin
          rd_en     = 1'b1;
          count_nxt = count_dec;
          if (count_dec < mark_r) begin
            mark_nxt = count_dec;
          end
        end
      end else begin
        if (count_r >= size_r) begin
          status = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CW'(RST_SIZE);
      mark_r  <= CW'(RST_SIZE);
      size_r  <= CW'(RST_SIZE);
    end else begin
      count_r <= count_nxt;
      mark_r  <= mark_nxt;
      size_r  <= size_nxt;
    end
  end

  // Entries below the low-water mark have not been pushed since the last
  // refill, so they still hold their refill value, size minus index minus one.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= req.freed_id;
    end
    if (rd_en) begin
      rd_data_r  <= mem[rd_addr];
      use_mem_r  <= (count_dec >= mark_r);
      fallback_r <= ID_W'(size_r - count_r);
    end
  end

  assign granted_id    = use_mem_r ? rd_data_r : fallback_r;
  assign rsp.status    = status;
  assign rsp.free_left = CNT_W'(count_nxt);
  assign rsp.size      = CNT_W'(size_r);

endmodule

`default_nettype wire

[rtl/tpbfl_checker.sv]
`default_nettype none

`include "two_pool_block_free_list_assert.svh"

module tpbfl_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        start,
  input wire        busy,
  input wire        in_pool,
  input wire        out_valid,
  input wire [9:0]  out_granted_id,
  input wire        out_result_pool,
  input wire [1:0]  out_status
);
  import tpbfl_pkg::*;

  // Every taken transaction yields its result in the next cycle, and no other.
  `TPBFL_ASSERT_NEXT(a_result_follows, start && !busy, out_valid)
  `TPBFL_ASSERT_NEXT(a_no_spurious, !(start && !busy), !out_valid)
  `TPBFL_ASSERT_SAME(a_pool_echo, out_valid, out_result_pool == $past(in_pool))
  // A failed request never hands out an id.
  `TPBFL_ASSERT_SAME(a_err_no_id, out_valid && (out_status != ST_OK), out_granted_id == '0)
  `TPBFL_ASSERT_SAME(a_status_code, out_valid,
                     (out_status == ST_OK) || (out_status == ST_EMPTY) || (out_status == ST_FULL))

endmodule

bind two_pool_block_free_list tpbfl_checker u_tpbfl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_pool         (in_pool),
  .out_valid       (out_valid),
  .out_granted_id  (out_granted_id),
  .out_result_pool (out_result_pool),
  .out_status      (out_status)
);

`default_nettype wire

[sim/two_pool_block_free_list_test.sv]
`default_nettype none

module two_pool_block_free_list_test;
  import tpbfl_pkg::*;

  localparam bit POOL_CPU = 1'b0;
  localparam bit POOL_GPU = 1'b1;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [ID_W-1:0]  granted_id;
    logic             result_pool;
    status_t          status;
    logic [CNT_W-1:0] free_left;
  } grant_result_t;

  class free_list_scoreboard;
    bit [ID_W-1:0] id_stack [2][MAX_BLOCKS_DEF];
    int unsigned   free_count [2];
    int unsigned   pool_size [2];
    grant_result_t pending [$];
    int            errors;

    function int unsigned capped_size(logic [APB_DATA_W-1:0] v);
      int unsigned s;
      s = v[CNT_W-1:0];
      return (s > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : s;
    endfunction

    function void refill(int p, int unsigned sz);
      for (int i = 0; i < MAX_BLOCKS_DEF; i++)
        id_stack[p][i] = (i < sz) ? ID_W'(sz - 1 - i) : '0;
      pool_size[p]  = sz;
      free_count[p] = sz;
    endfunction

    function grant_result_t note_request(bit func, bit pool, bit [ID_W-1:0] id);
      grant_result_t r;
      int p;
      p = pool;
      r.granted_id  = '0;
      r.result_pool = pool;
      r.status      = ST_OK;
      if (func == FUNC_ALLOC) begin
        if (free_count[p] == 0) begin
          r.status = ST_EMPTY;
        end else begin
          free_count[p]--;
          r.granted_id = id_stack[p][free_count[p]];
        end
      end else begin
        if (free_count[p] >= pool_size[p] || free_count[p] >= MAX_BLOCKS_DEF) begin
          r.status = ST_FULL;
        end else begin
          id_stack[p][free_count[p]] = id;
          free_count[p]++;
        end
      end
      r.free_left = CNT_W'(free_count[p]);
      pending = {pending, r};
      return r;
    endfunction

    function void check_result(grant_result_t got);
      grant_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: result transaction with nothing outstanding (id %0d pool %0d)",
                 $time, got.granted_id, got.result_pool);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.granted_id !== want.granted_id) begin
        $display("%0t: granted_id expected %0d got %0d", $time, want.granted_id,
                 got.granted_id);
        errors++;
      end
      if (got.result_pool !== want.result_pool) begin
        $display("%0t: result_pool expected %0d got %0d", $time, want.result_pool,
                 got.result_pool);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.free_left !== want.free_left) begin
        $display("%0t: free_left expected %0d got %0d", $time, want.free_left,
                 got.free_left);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  in_func = 1'b0;
  logic                  in_pool = 1'b0;
  logic [ID_W-1:0]       in_freed_id = '0;
  logic                  out_valid;
  logic [ID_W-1:0]       out_granted_id;
  logic                  out_result_pool;
  logic [1:0]            out_status;
  logic [CNT_W-1:0]      out_free_left;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  free_list_scoreboard sb;
  bit [ID_W-1:0] cpu_held [$];
  bit [ID_W-1:0] gpu_held [$];
  int n_alloc, n_free, n_empty, n_full, n_settings;
  int idle_cycles;

  two_pool_block_free_list dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_pool(in_pool), .in_freed_id(in_freed_id),
    .out_valid(out_valid), .out_granted_id(out_granted_id),
    .out_result_pool(out_result_pool), .out_status(out_status),
    .out_free_left(out_free_left),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Results are sampled mid-cycle, well away from the edge that changes them.
  always @(negedge clk) begin
    grant_result_t got;
    if (rst_n && out_valid) begin
      got.granted_id  = out_granted_id;
      got.result_pool = out_result_pool;
      got.status      = status_t'(out_status);
      got.free_left   = out_free_left;
      sb.check_result(got);
    end
  end

  always @(negedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic cfg_access(bit wr, logic reg_idx, logic [APB_DATA_W-1:0] data,
                            output logic [APB_DATA_W-1:0] rd);
    bit done;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      done = pready;
      rd   = prdata;
      @(posedge clk);
    end while (!done);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_size_reg(logic reg_idx);
    logic [APB_DATA_W-1:0] rd;
    cfg_access(1'b0, reg_idx, '0, rd);
    if (rd !== APB_DATA_W'(sb.pool_size[reg_idx])) begin
      $display("%0t: size register %0d expected %0d got %0d", $time, reg_idx,
               sb.pool_size[reg_idx], rd);
      sb.errors++;
    end
  endtask

  task automatic set_pool_size(logic reg_idx, logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] rd;
    cfg_access(1'b1, reg_idx, value, rd);
    sb.refill(reg_idx, sb.capped_size(value));
    if (reg_idx == REG_CPU_POOL_BLOCKS) cpu_held.delete();
    else gpu_held.delete();
    n_settings++;
    @(posedge clk);
    check_size_reg(reg_idx);
  endtask

  task automatic issue_request(bit func, bit pool, bit [ID_W-1:0] id);
    grant_result_t want;
    bit ready;
    start       <= 1'b1;
    in_func     <= func;
    in_pool     <= pool;
    in_freed_id <= id;
    do begin
      @(negedge clk);
      ready = !busy;
      @(posedge clk);
    end while (!ready);
    want = sb.note_request(func, pool, id);
    if (func == FUNC_ALLOC) n_alloc++;
    else n_free++;
    if (want.status == ST_EMPTY) n_empty++;
    if (want.status == ST_FULL) n_full++;
    if (func == FUNC_ALLOC && want.status == ST_OK) begin
      if (pool == POOL_CPU) cpu_held = {cpu_held, want.granted_id};
      else gpu_held = {gpu_held, want.granted_id};
    end
  endtask

  // Mostly hands back ids that were granted earlier; the rest are arbitrary ids,
  // which covers foreign and repeated frees.
  task automatic random_request(int alloc_pct);
    bit func;
    bit pool;
    bit [ID_W-1:0] id;
    int k;
    func = ($urandom_range(99) < alloc_pct) ? FUNC_ALLOC : FUNC_FREE;
    pool = $urandom_range(1);
    id   = $urandom_range(MAX_BLOCKS_DEF - 1);
    if (func == FUNC_FREE && $urandom_range(9) < 8) begin
      if (pool == POOL_CPU && cpu_held.size() > 0) begin
        k  = $urandom_range(cpu_held.size() - 1);
        id = cpu_held[k];
        cpu_held.delete(k);
      end else if (pool == POOL_GPU && gpu_held.size() > 0) begin
        k  = $urandom_range(gpu_held.size() - 1);
        id = gpu_held[k];
        gpu_held.delete(k);
      end
    end
    issue_request(func, pool, id);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  function automatic logic [APB_DATA_W-1:0] random_size_word();
    logic [APB_DATA_W-1:0] v;
    case ($urandom_range(9))
      0: v = 0;
      1: v = MAX_BLOCKS_DEF;
      2: v = $urandom_range(MAX_BLOCKS_DEF + 1, 2047);
      3: v = $urandom_range(MAX_BLOCKS_DEF);
      default: v = $urandom_range(1, 12);
    endcase
    // Bits above the register width must be dropped by the block.
    if ($urandom_range(3) == 0) v = v | ($urandom & ~32'h7FF);
    return v;
  endfunction

  initial begin
    int burst;
    int gap;
    int alloc_pct;
    bit steady;
    sb = new();
    sb.refill(POOL_CPU, POOL_RESET_SIZE);
    sb.refill(POOL_GPU, POOL_RESET_SIZE);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    check_size_reg(REG_CPU_POOL_BLOCKS);
    @(posedge clk);
    check_size_reg(REG_GPU_POOL_BLOCKS);
    @(posedge clk);

    // Fresh pools grant the smallest ids first; a full pool refuses a free.
    issue_request(FUNC_ALLOC, POOL_CPU, 10'h3FF);
    issue_request(FUNC_ALLOC, POOL_CPU, 10'h000);
    issue_request(FUNC_ALLOC, POOL_GPU, 10'h155);
    issue_request(FUNC_FREE, POOL_GPU, 10'h3FF);
    issue_request(FUNC_ALLOC, POOL_GPU, 10'h2AA);
    issue_request(FUNC_FREE, POOL_CPU, 10'h000);
    issue_request(FUNC_FREE, POOL_CPU, 10'h001);
    issue_request(FUNC_FREE, POOL_CPU, 10'h005);
    drain();

    // A pool of size zero refuses everything.
    set_pool_size(REG_CPU_POOL_BLOCKS, 32'd0);
    issue_request(FUNC_ALLOC, POOL_CPU, 10'h000);
    issue_request(FUNC_FREE, POOL_CPU, 10'h007);
    drain();

    // Oversized settings saturate at the maximum pool size.
    set_pool_size(REG_GPU_POOL_BLOCKS, 32'd2047);
    issue_request(FUNC_ALLOC, POOL_GPU, 10'h3FF);
    drain();

    set_pool_size(REG_CPU_POOL_BLOCKS, 32'hFFFF_F803);
    issue_request(FUNC_ALLOC, POOL_CPU, 10'h000);
    issue_request(FUNC_ALLOC, POOL_CPU, 10'h000);
    issue_request(FUNC_ALLOC, POOL_CPU, 10'h000);
    issue_request(FUNC_ALLOC, POOL_CPU, 10'h000);
    issue_request(FUNC_FREE, POOL_CPU, 10'h3FF);
    issue_request(FUNC_FREE, POOL_CPU, 10'h3FF);
    issue_request(FUNC_FREE, POOL_CPU, 10'h200);
    issue_request(FUNC_FREE, POOL_CPU, 10'h009);
    issue_request(FUNC_ALLOC, POOL_CPU, 10'h000);
    drain();
    set_pool_size(REG_CPU_POOL_BLOCKS, 32'd1);
    issue_request(FUNC_ALLOC, POOL_CPU, 10'h000);
    issue_request(FUNC_ALLOC, POOL_CPU, 10'h000);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph != 0) begin
        if ($urandom_range(2) != 1) set_pool_size(REG_CPU_POOL_BLOCKS, random_size_word());
        @(posedge clk);
        if ($urandom_range(2) != 0) set_pool_size(REG_GPU_POOL_BLOCKS, random_size_word());
      end else begin
        set_pool_size(REG_CPU_POOL_BLOCKS, MAX_BLOCKS_DEF);
        @(posedge clk);
        set_pool_size(REG_GPU_POOL_BLOCKS, 32'd5);
      end
      alloc_pct = $urandom_range(30, 70);
      steady    = (ph % 3 == 1);
      burst     = $urandom_range(1, 16);
      for (int k = 0; k < 56; k++) begin
        random_request(alloc_pct);
        burst--;
        if (burst == 0) begin
          gap = steady ? 0 : $urandom_range(0, 6);
          if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          burst = $urandom_range(1, 16);
        end
      end
      drain();
    end

    $display("Covered %0d allocate and %0d free transactions over %0d size settings,",
             n_alloc, n_free, n_settings);
    $display("including %0d empty-pool and %0d full-pool refusals.", n_empty, n_full);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
